// File: src/sfir_pkg.sv
// Shared types and constants for the strided FIR filter.
package sfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int NUM_COEF   = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_BIAS = 8192;
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       clear_history;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } out_item_t;

endpackage

// File: src/sfir_tap_cell.sv
// One tap cell: adds its tap product to the running sum and hands the beat on.
module sfir_tap_cell #(
  parameter int TAPS  = 8,
  parameter int IDX   = 0,
  parameter int ACC_W = 35
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   valid_in,
  input  logic signed [ACC_W-1:0]                acc_in,
  input  logic [TAPS-1:0][sfir_pkg::SAMPLE_W-1:0] taps_in,
  input  logic [sfir_pkg::COEF_W-1:0]            coef,
  output logic                                   valid_out,
  output logic signed [ACC_W-1:0]                acc_out,
  output logic [TAPS-1:0][sfir_pkg::SAMPLE_W-1:0] taps_out
);
  import sfir_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum;

  assign prod = $signed(taps_in[IDX]) * $signed(coef);
  assign sum  = acc_in + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_out  <= sum;
      taps_out <= taps_in;
    end
  end

endmodule

// File: src/sfir_round_sat.sv
// Output stage: round the full sum to Q1.15, saturate, and hold the result beat.
module sfir_round_sat #(
  parameter int ACC_W = 35
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    valid_in,
  input  logic signed [ACC_W-1:0] acc_in,
  output logic                    out_valid,
  output sfir_pkg::out_item_t     out_data
);
  import sfir_pkg::*;

  localparam int R_W = ACC_W + 1 - FRAC_SHIFT;
  localparam logic signed [R_W-1:0] R_MAX = R_W'(OUT_MAX);
  localparam logic signed [R_W-1:0] R_MIN = R_W'(OUT_MIN);

  logic signed [ACC_W:0]  biased;
  logic signed [R_W-1:0]  rounded;
  out_item_t              res;

  assign biased  = {acc_in[ACC_W-1], acc_in} + (ACC_W+1)'(ROUND_BIAS);
  // floor division by 2^14: drop the low bits of the two's complement value
  assign rounded = $signed(biased[ACC_W:FRAC_SHIFT]);

  always_comb begin
    res.clipped  = 1'b0;
    res.filtered = rounded[SAMPLE_W-1:0];
    if (rounded > R_MAX) begin
      res.filtered = SAMPLE_W'(OUT_MAX);
      res.clipped  = 1'b1;
    end else if (rounded < R_MIN) begin
      res.filtered = SAMPLE_W'(OUT_MIN);
      res.clipped  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule

// File: src/strided_fir_filter_unit.sv
// Strided FIR filter top level: history line, coefficient registers and cell chain.
//
// Takes one sample per clock while the output is not stalled and returns one filtered
// sample per input, in order. Each accepted sample picks up its tap samples from the
// history line on entry and then walks a chain of TAPS tap cells, one multiply-add
// per cell, followed by a round-and-saturate output register. The whole chain
// advances together; it holds only while the output register carries a result that
// has not been taken, so in_ready follows out_ready in that case. Coefficients are
// written through the cfg port (index 0..7); each cell reads its coefficient as a
// sample passes it, so write them only while no sample is in the chain. Indexes at
// or above TAPS are stored only.
module strided_fir_filter_unit #(
  parameter int TAPS   = 8,
  parameter int STRIDE = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfir_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfir_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sfir_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sfir_pkg::COEF_W-1:0]         cfg_wdata
);
  import sfir_pkg::*;

  localparam int HIST_LEN = (TAPS - 1) * STRIDE;
  localparam int ACC_W    = PROD_W + $clog2(TAPS);

  logic [NUM_COEF-1:0][COEF_W-1:0]   coef;
  logic [HIST_LEN-1:0][SAMPLE_W-1:0] hist;
  logic [TAPS-1:0][SAMPLE_W-1:0]     tap_vec;
  logic                              adv;
  logic                              in_fire;

  logic                              vld   [TAPS+1];
  logic signed [ACC_W-1:0]           acc   [TAPS+1];
  logic [TAPS-1:0][SAMPLE_W-1:0]     taps  [TAPS+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_we) begin
      coef[cfg_addr] <= cfg_wdata;
    end
  end

  // clear drops the old samples before the new one enters
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (in_fire) begin
      hist[0] <= in_data.sample_in;
      for (int j = 1; j < HIST_LEN; j++) begin
        hist[j] <= in_data.clear_history ? '0 : hist[j-1];
      end
    end
  end

  always_comb begin
    tap_vec[0] = in_data.sample_in;
    for (int k = 1; k < TAPS; k++) begin
      tap_vec[k] = in_data.clear_history ? '0 : hist[k*STRIDE-1];
    end
  end

  assign vld[0]  = in_valid;
  assign acc[0]  = '0;
  assign taps[0] = tap_vec;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    sfir_tap_cell #(
      .TAPS  (TAPS),
      .IDX   (k),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .valid_in  (vld[k]),
      .acc_in    (acc[k]),
      .taps_in   (taps[k]),
      .coef      (coef[k]),
      .valid_out (vld[k+1]),
      .acc_out   (acc[k+1]),
      .taps_out  (taps[k+1])
    );
  end

  sfir_round_sat #(
    .ACC_W (ACC_W)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (vld[TAPS]),
    .acc_in    (acc[TAPS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(vld[1]) && $stable(vld[TAPS]) && $stable(acc[TAPS])))
    else $error("cell chain moved during a stall");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clipped) |->
      (out_data.filtered == SAMPLE_W'(OUT_MAX) || out_data.filtered == SAMPLE_W'(OUT_MIN)))
    else $error("clipped result not at a rail");

  a_clear_empties_history: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.clear_history && (HIST_LEN > 1)) |=> (hist[HIST_LEN-1] == '0))
    else $error("history not cleared");
`endif

endmodule
